// ----- src/nisr_pkg.sv -----
// ----------------------------------------------------------------------------
// nisr_pkg: shared types and constants
// Word formats, status codes and queue entry layout for the nibble image
// stream to RGB converter.
// ----------------------------------------------------------------------------
package nisr_pkg;

  // default pixel capacity of one image
  localparam int MAX_PIXELS_DEF = 1048576;
  // width of the pixel index field on the result channel
  localparam int PIX_IDX_W      = 20;
  // entries between parser and pixel emitter (power of two)
  localparam int QUEUE_DEPTH    = 4;

  // file magic "HI"
  localparam logic [7:0] MAGIC_0 = 8'h48;
  localparam logic [7:0] MAGIC_1 = 8'h49;

  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_TOO_BIG   = 2'd2
  } status_t;

  // input word
  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
  } nisr_in_t;

  // result word
  typedef struct packed {
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [3:0]           color_code;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    status_t              status;
    logic                 last;
  } nisr_out_t;

  // queue entry: one data byte (one or two pixels) or one error
  typedef struct packed {
    logic [7:0]           data;
    logic [PIX_IDX_W-1:0] base_idx;
    status_t              status;
    logic                 second;   // high nibble is a pixel too
    logic                 last_lo;
    logic                 last_hi;
  } nisr_item_t;

endpackage

// ----- src/nisr_front.sv -----
// ----------------------------------------------------------------------------
// nisr_front: header parser
// Checks the magic, collects size, width and height, sizes the image and
// turns each usable data byte, or an error, into one queue entry.
// ----------------------------------------------------------------------------
module nisr_front #(
  parameter int MAX_PIXELS = nisr_pkg::MAX_PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nisr_pkg::nisr_in_t   in_data,
  output logic                 q_push,
  output nisr_pkg::nisr_item_t q_item,
  input  logic                 q_full
);

  localparam int NpixW = $clog2(MAX_PIXELS + 1);
  localparam int LimW  = $clog2((MAX_PIXELS + 1) / 2 + 1);
  localparam int CntW  = (LimW > 2) ? LimW : 2;
  localparam int CmpW  = NpixW + 1;
  localparam int IdxW  = nisr_pkg::PIX_IDX_W;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_SIZE, PH_WIDTH, PH_HEIGHT, PH_MUL, PH_CHK, PH_DATA, PH_HALT
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [31:0]       width_r, width_nxt;
  logic [31:0]       height_r, height_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [NpixW-1:0]  npix_r, npix_nxt;
  logic [LimW-1:0]   limit_r, limit_nxt;

  logic              accept;
  phase_t            eff_phase;
  logic [CntW-1:0]   eff_cnt;
  logic [CntW-1:0]   cnt_inc;
  logic [1:0]        lane;
  logic [CmpW-1:0]   pos_lo;
  logic [CmpW-1:0]   npix_c;
  logic              over;
  logic              empty_img;
  logic [CmpW-1:0]   need_c;
  logic [LimW-1:0]   limit_c;

  // handshake: stall while sizing the image or when the queue is full
  assign in_ready = !(phase_r == PH_MUL || phase_r == PH_CHK) && !q_full;
  assign accept   = in_valid && in_ready;

  // frame_start restarts with this byte as first magic byte
  assign eff_phase = in_data.frame_start ? PH_MAGIC : phase_r;
  assign eff_cnt   = in_data.frame_start ? '0 : cnt_r;
  assign cnt_inc   = eff_cnt + CntW'(1);
  assign lane      = eff_cnt[1:0];

  // pixel position of the low nibble
  assign pos_lo = CmpW'(eff_cnt) << 1;
  assign npix_c = CmpW'(npix_r);

  // image sizing from the registered product
  assign over      = prod_r > 64'(MAX_PIXELS);
  assign empty_img = (prod_r == 64'd0) || (size_r == 32'd0);
  assign need_c    = (CmpW'(prod_r[NpixW-1:0]) + CmpW'(1)) >> 1;
  assign limit_c   = (size_r < 32'(need_c)) ? LimW'(size_r) : LimW'(need_c);

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    size_nxt   = size_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    prod_nxt   = prod_r;
    npix_nxt   = npix_r;
    limit_nxt  = limit_r;
    q_push     = 1'b0;
    q_item.data     = in_data.byte_value;
    q_item.base_idx = IdxW'(pos_lo);
    q_item.status   = nisr_pkg::ST_PIXEL;
    q_item.second   = (pos_lo + CmpW'(1)) < npix_c;
    q_item.last_lo  = (pos_lo + CmpW'(1)) == npix_c;
    q_item.last_hi  = (pos_lo + CmpW'(2)) == npix_c;

    if (accept) begin
      case (eff_phase)
        PH_MAGIC: begin
          if (in_data.byte_value != (eff_cnt[0] ? nisr_pkg::MAGIC_1 : nisr_pkg::MAGIC_0))
          begin
            q_push          = 1'b1;
            q_item.data     = '0;
            q_item.base_idx = '0;
            q_item.status   = nisr_pkg::ST_BAD_MAGIC;
            q_item.second   = 1'b0;
            q_item.last_lo  = 1'b1;
            q_item.last_hi  = 1'b0;
            phase_nxt       = PH_HALT;
          end else if (eff_cnt[0]) begin
            phase_nxt = PH_SIZE;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_MAGIC;
            cnt_nxt   = cnt_inc;
          end
        end
        PH_SIZE, PH_WIDTH, PH_HEIGHT: begin
          // little-endian fields, one byte lane per word
          if (eff_phase == PH_SIZE) begin
            size_nxt[8*lane +: 8] = in_data.byte_value;
          end else if (eff_phase == PH_WIDTH) begin
            width_nxt[8*lane +: 8] = in_data.byte_value;
          end else begin
            height_nxt[8*lane +: 8] = in_data.byte_value;
          end
          if (lane == 2'd3) begin
            cnt_nxt = '0;
            if (eff_phase == PH_SIZE) begin
              phase_nxt = PH_WIDTH;
            end else if (eff_phase == PH_WIDTH) begin
              phase_nxt = PH_HEIGHT;
            end else begin
              phase_nxt = PH_MUL;
            end
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_DATA: begin
          q_push  = 1'b1;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CntW'(limit_r)) begin
            phase_nxt = PH_HALT;
          end
        end
        default: begin
          // finished or errored frame: words are dropped
        end
      endcase
    end else if (phase_r == PH_MUL) begin
      prod_nxt  = 64'(width_r) * 64'(height_r);
      phase_nxt = PH_CHK;
    end else if (phase_r == PH_CHK) begin
      if (over) begin
        if (!q_full) begin
          q_push          = 1'b1;
          q_item.data     = '0;
          q_item.base_idx = '0;
          q_item.status   = nisr_pkg::ST_TOO_BIG;
          q_item.second   = 1'b0;
          q_item.last_lo  = 1'b1;
          q_item.last_hi  = 1'b0;
          phase_nxt       = PH_HALT;
        end
      end else begin
        npix_nxt  = NpixW'(prod_r);
        limit_nxt = limit_c;
        cnt_nxt   = '0;
        phase_nxt = empty_img ? PH_HALT : PH_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
    size_r   <= size_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    prod_r   <= prod_nxt;
    npix_r   <= npix_nxt;
    limit_r  <= limit_nxt;
  end

`ifndef ASSERT_OFF
  // pixel entries only come from data bytes of the current frame
  a_pixel_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_item.status == nisr_pkg::ST_PIXEL)
      |-> (phase_r == PH_DATA) && !in_data.frame_start)
    else $error("pixel entry outside data phase");

  // the product is checked right after it is formed
  a_mul_to_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MUL) |=> (phase_r == PH_CHK))
    else $error("sizing sequence broken");
`endif

endmodule

// ----- src/nisr_queue.sv -----
// ----------------------------------------------------------------------------
// nisr_queue: entry queue
// Short FIFO between the parser and the pixel emitter.
// ----------------------------------------------------------------------------
module nisr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  nisr_pkg::nisr_item_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output nisr_pkg::nisr_item_t rd_data,
  output logic                 empty
);

  localparam int Depth = nisr_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  nisr_pkg::nisr_item_t mem_r [Depth];
  logic [PtrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]      count_r, count_nxt;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = count_r == CntW'(Depth);
  assign empty   = count_r == '0;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PtrW'(1) : rd_ptr_r;
    count_nxt  = count_r + CntW'(do_wr) - CntW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef ASSERT_OFF
  // producer respects full, so no entry is dropped
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("write into full queue");
`endif

endmodule

// ----- src/nisr_back.sv -----
// ----------------------------------------------------------------------------
// nisr_back: pixel emitter
// Expands each queue entry into one or two result words with palette RGB,
// behind an output register.
// ----------------------------------------------------------------------------
module nisr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nisr_pkg::nisr_item_t q_item,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nisr_pkg::nisr_out_t  out_data
);

  localparam int IdxW = nisr_pkg::PIX_IDX_W;

  logic                out_valid_r, out_valid_nxt;
  nisr_pkg::nisr_out_t out_r, out_nxt;
  logic                hi_sel_r, hi_sel_nxt;
  logic                load;
  logic                take;
  logic [3:0]          nib;
  nisr_pkg::nisr_out_t word_c;

  // 16-color palette: levels 0/85/170/255, brown has green halved
  function automatic nisr_pkg::nisr_out_t pixel_word(input logic [IdxW-1:0] idx,
                                                     input logic [3:0] c,
                                                     input logic is_last);
    nisr_pkg::nisr_out_t w;
    logic [7:0]          hi;
    hi            = c[3] ? 8'd85 : 8'd0;
    w.pixel_index = idx;
    w.color_code  = c;
    w.red         = (c[2] ? 8'd170 : 8'd0) + hi;
    w.green       = (c[1] ? ((c == 4'd6) ? 8'd85 : 8'd170) : 8'd0) + hi;
    w.blue        = (c[0] ? 8'd170 : 8'd0) + hi;
    w.status      = nisr_pkg::ST_PIXEL;
    w.last        = is_last;
    return w;
  endfunction

  assign load = !out_valid_r || out_ready;
  assign take = load && !q_empty;
  assign nib  = hi_sel_r ? q_item.data[7:4] : q_item.data[3:0];

  // word for the current half of the head entry
  always_comb begin
    if (q_item.status != nisr_pkg::ST_PIXEL) begin
      word_c        = '0;
      word_c.status = q_item.status;
      word_c.last   = 1'b1;
    end else if (hi_sel_r) begin
      word_c = pixel_word({q_item.base_idx[IdxW-1:1], 1'b1}, nib, q_item.last_hi);
    end else begin
      word_c = pixel_word(q_item.base_idx, nib, q_item.last_lo);
    end
  end

  // pop as the last word that the entry yields is taken
  assign q_pop = take && (q_item.status != nisr_pkg::ST_PIXEL || hi_sel_r ||
                          !q_item.second);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    hi_sel_nxt    = hi_sel_r;
    if (load) begin
      out_valid_nxt = take;
      if (take) begin
        out_nxt    = word_c;
        hi_sel_nxt = (q_item.status == nisr_pkg::ST_PIXEL) && !hi_sel_r &&
                     q_item.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hi_sel_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hi_sel_r    <= hi_sel_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // a pending high nibble keeps its entry at the queue head
  a_hi_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    hi_sel_r |-> !q_empty)
    else $error("high nibble pending with empty queue");

  // error words always close the frame
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != nisr_pkg::ST_PIXEL) |-> out_r.last)
    else $error("error word without last");
`endif

endmodule

// ----- src/nibble_image_stream_to_rgb.sv -----
// ----------------------------------------------------------------------------
// nibble_image_stream_to_rgb: nibble image file to RGB pixel stream
// Parses a byte stream ("HI", size, width, height, packed 4-bit pixels)
// and emits one result word per pixel with its palette RGB levels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one file byte per word; frame_start restarts parsing with this
//           byte as the first magic byte.
//   out_* : one word per pixel (index, color, RGB, status, last), or a
//           single error word (bad magic, image over capacity) with last set.
// Sequence: a data byte's first pixel passes through the queue and the output
//   register before it shows on out_valid; its second pixel follows from the same
//   queue entry. After the last height byte the image is sized (32x32 multiply,
//   then compare) while in_ready is low; a capacity error appears after those.
// Throughput: one result word per cycle while out_ready is high. The pixel
//   emitter sets the data rate, splitting each byte into one or two words;
//   header bytes are taken one per cycle while the queue is not full.
// Stalls: a four-entry queue sits between parser and emitter, and the
//   output word is registered; when out_ready is low the queue fills and
//   in_ready drops.
// Reset: synchronous, active low; parser returns to waiting for magic and
//   the queue and output register empty.
// ----------------------------------------------------------------------------
module nibble_image_stream_to_rgb #(
  parameter int MAX_PIXELS = nisr_pkg::MAX_PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nisr_pkg::nisr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nisr_pkg::nisr_out_t out_data
);

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  nisr_pkg::nisr_item_t q_wr_item;
  nisr_pkg::nisr_item_t q_rd_item;

  // header parser and data byte classifier
  nisr_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_item   (q_wr_item),
    .q_full   (q_full)
  );

  // decoupling queue
  nisr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_item),
    .empty   (q_empty)
  );

  // pixel emitter
  nisr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_rd_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
